[design/k_permutation_enumerator_core_macros.svh]
// assertion macros shared by the k-permutation enumerator checker
`ifndef K_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH
`define K_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define KPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define KPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/kperm_pkg.sv]
// shared types and constants of the k-permutation enumerator
`default_nettype none

package kperm_pkg;

	// default sizes
	localparam int DEF_MAX_VALUES = 16;
	localparam int DEF_MAX_LENGTH = 16;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_COUNT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_LENGTH = 2'd1;

	// fixed payload widths
	localparam int POS_W = 4;
	localparam int VAL_W = 4;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_BACK,
		ST_FIND,
		ST_FILL,
		ST_ERD,
		ST_ELD,
		ST_EMPTY,
		ST_END
	} kperm_state_t;

endpackage

`default_nettype wire

[design/kperm_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module kperm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[design/k_permutation_enumerator_core.sv]
// Lexicographic k-permutation enumerator, one sequence per request.
//
// Configure value_count (n) and sequence_length (r) through the write port
// while idle; any write to a known register restarts the enumeration.
// Each accepted input word with next_request set yields either the next
// sequence, as r output words (position 0..r-1, last_of_run on the final
// one), a single empty-sequence word when r is 0 at the start, or a single
// word with found low when the enumeration has ended or the sizes are
// invalid; it then starts over. A word with next_request low is absorbed.
// Flow: a first request seeds positions 0..r-1 into the sequence ram, then
// streams the sequence out; later requests step back one position at a
// time (sequence ram read, then the find-free unit), refill the later
// positions, then stream out. Invalid sizes go straight to the end state.
// Work is serial: one sequence ram read port and a single find-free unit.
// in_ready is high only while the sequencer is idle. The output register
// holds a word until out_ready; a stalled receiver stops the sequencer.
// Reset clears the registers, the enumeration state and the output valid.
`default_nettype none

module k_permutation_enumerator_core
	import kperm_pkg::*;
#(
	parameter int MAX_VALUES = DEF_MAX_VALUES,
	parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   next_request,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        found,
	output logic      [POS_W-1:0]       position,
	output logic      [VAL_W-1:0]       element_value,
	output logic                        empty_sequence,
	output logic                        last_of_run
);

	localparam int VW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int NCW = $clog2(MAX_VALUES + 1);
	localparam int LW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LCW = $clog2(MAX_LENGTH + 1);
	localparam int MW  = MAX_VALUES;

	kperm_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] value_count_q, sequence_length_q;
	logic                  running_q, running_d;
	logic [MW-1:0]         mask_q, mask_d, mask_clr;
	logic [LCW-1:0]        idx_q, idx_d, idx_inc, r_len;
	logic [NCW-1:0]        n_eff;
	logic                  bad_size, cfg_hit;

	// sequence ram port signals
	logic          ram_we, ram_re;
	logic [LW-1:0] ram_wa, ram_ra;
	logic [VW-1:0] ram_wd, ram_rd;

	// find-free unit
	logic [MW-1:0]  ff_mask;
	logic [NCW-1:0] ff_from;
	logic           ff_found;
	logic [VW-1:0]  ff_val;

	// output register
	logic             out_valid_q, out_valid_d, out_free, load;
	logic             ld_found, ld_empty, ld_last;
	logic [POS_W-1:0] ld_pos;
	logic [VAL_W-1:0] ld_val;
	logic             found_q, empty_q, last_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;

	// effective sizes
	assign n_eff    = (32'(value_count_q) > 32'(MAX_VALUES)) ? NCW'(MAX_VALUES)
		: NCW'(value_count_q);
	assign bad_size = (32'(sequence_length_q) > 32'(MAX_LENGTH))
		|| (32'(sequence_length_q) > 32'(n_eff));
	assign r_len    = LCW'(sequence_length_q);
	assign cfg_hit  = cfg_write
		&& ((cfg_index == REG_VALUE_COUNT) || (cfg_index == REG_SEQUENCE_LENGTH));
	assign idx_inc  = idx_q + LCW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q     <= '0;
			sequence_length_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_VALUE_COUNT) begin
				value_count_q <= cfg_data;
			end
			if (cfg_index == REG_SEQUENCE_LENGTH) begin
				sequence_length_q <= cfg_data;
			end
		end
	end

	// sequence store, one entry per position
	kperm_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_LENGTH)
	) u_seq_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	// find-free unit: smallest unused value v with from <= v < n
	always_comb begin
		ff_found = 1'b0;
		ff_val   = '0;
		for (int v = MAX_VALUES - 1; v >= 0; v--) begin
			if (!ff_mask[v] && (NCW'(v) >= ff_from) && (NCW'(v) < n_eff)) begin
				ff_found = 1'b1;
				ff_val   = VW'(v);
			end
		end
	end

	// value currently held at the scanned position, released from the mask
	assign mask_clr = mask_q & ~(MW'(1) << ram_rd);

	// sequencer next state and datapath control
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		mask_d    = mask_q;
		running_d = running_q;
		ram_we    = 1'b0;
		ram_wa    = idx_q[LW-1:0];
		ram_wd    = ff_val;
		ram_re    = 1'b0;
		ram_ra    = idx_q[LW-1:0];
		ff_mask   = mask_q;
		ff_from   = '0;
		load      = 1'b0;
		ld_found  = 1'b0;
		ld_pos    = '0;
		ld_val    = '0;
		ld_empty  = 1'b0;
		ld_last   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && next_request) begin
					if (bad_size) begin
						state_d = ST_END;
					end else if (!running_q) begin
						mask_d = '0;
						idx_d  = '0;
						state_d = (r_len == '0) ? ST_EMPTY : ST_INIT;
					end else if (r_len == '0) begin
						state_d = ST_END;
					end else begin
						idx_d   = r_len - LCW'(1);
						state_d = ST_BACK;
					end
				end
			end
			// seed 0,1,...,r-1
			ST_INIT: begin
				ram_we = 1'b1;
				ram_wd = VW'(idx_q);
				mask_d = mask_q | (MW'(1) << idx_q);
				idx_d  = idx_inc;
				if (idx_inc == r_len) begin
					idx_d     = '0;
					running_d = 1'b1;
					state_d   = ST_ERD;
				end
			end
			// fetch the entry at the scanned position
			ST_BACK: begin
				ram_re  = 1'b1;
				state_d = ST_FIND;
			end
			// try to bump the entry to the next free larger value
			ST_FIND: begin
				ff_mask = mask_clr;
				ff_from = NCW'(ram_rd) + NCW'(1);
				if (ff_found) begin
					ram_we = 1'b1;
					mask_d = mask_clr | (MW'(1) << ff_val);
					idx_d  = idx_inc;
					if (idx_inc == r_len) begin
						idx_d   = '0;
						state_d = ST_ERD;
					end else begin
						state_d = ST_FILL;
					end
				end else begin
					mask_d = mask_clr;
					if (idx_q == '0) begin
						state_d = ST_END;
					end else begin
						idx_d   = idx_q - LCW'(1);
						state_d = ST_BACK;
					end
				end
			end
			// refill the tail with the smallest free values
			ST_FILL: begin
				if (ff_found) begin
					ram_we = 1'b1;
					mask_d = mask_q | (MW'(1) << ff_val);
					idx_d  = idx_inc;
					if (idx_inc == r_len) begin
						idx_d   = '0;
						state_d = ST_ERD;
					end
				end else begin
					state_d = ST_END;
				end
			end
			// prime the read of position 0
			ST_ERD: begin
				ram_re  = 1'b1;
				state_d = ST_ELD;
			end
			// stream one word per cycle while the output register is free, reading ahead
			ST_ELD: begin
				if (out_free) begin
					load     = 1'b1;
					ld_found = 1'b1;
					ld_pos   = POS_W'(idx_q);
					ld_val   = VAL_W'(ram_rd);
					ld_last  = (idx_inc == r_len);
					if (idx_inc == r_len) begin
						idx_d   = '0;
						state_d = ST_IDLE;
					end else begin
						idx_d  = idx_inc;
						ram_re = 1'b1;
						ram_ra = idx_inc[LW-1:0];
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					load      = 1'b1;
					ld_found  = 1'b1;
					ld_empty  = 1'b1;
					ld_last   = 1'b1;
					running_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_END: begin
				if (out_free) begin
					load      = 1'b1;
					ld_last   = 1'b1;
					running_d = 1'b0;
					mask_d    = '0;
					idx_d     = '0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// register write restarts the enumeration
		if (cfg_hit) begin
			running_d = 1'b0;
			mask_d    = '0;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			mask_q    <= '0;
			running_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			mask_q    <= mask_d;
			running_q <= running_d;
		end
	end

	// output valid
	always_comb begin
		out_valid_d = out_valid_q && !out_ready;
		if (load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= ld_found;
			pos_q   <= ld_pos;
			val_q   <= ld_val;
			empty_q <= ld_empty;
			last_q  <= ld_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign position       = pos_q;
	assign element_value  = val_q;
	assign empty_sequence = empty_q;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

[design/kperm_checker.sv]
// port-level checks for the k-permutation enumerator, bound to the top level
`default_nettype none

`include "k_permutation_enumerator_core_macros.svh"

module kperm_checker
	import kperm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   found,
	input wire logic [POS_W-1:0]       position,
	input wire logic [VAL_W-1:0]       element_value,
	input wire logic                   empty_sequence,
	input wire logic                   last_of_run
);

	// a stalled result word holds
	`KPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(found) && $stable(position) && $stable(element_value)
		&& $stable(last_of_run), "result word changed while stalled")

	// an end report is a lone, zeroed word
	`KPE_ASSERT_NOW(a_end_word, clk, arst_n, out_valid && !found,
		last_of_run && (position == '0) && (element_value == '0) && !empty_sequence,
		"end report carries element data")

	// the empty sequence is a single found word
	`KPE_ASSERT_NOW(a_empty_word, clk, arst_n, out_valid && empty_sequence,
		found && last_of_run && (position == '0), "malformed empty-sequence word")

	// no request is taken while a sequence is still streaming
	`KPE_ASSERT_NOW(a_busy_mid_seq, clk, arst_n, out_valid && found && !last_of_run,
		!in_ready, "request accepted in the middle of a sequence")

endmodule

bind k_permutation_enumerator_core kperm_checker u_kperm_checker (.*);

`default_nettype wire

[tb/sv/k_permutation_enumerator_core_checker.sv]
// checker for the k-permutation enumerator: predicts result words and compares them
`default_nettype none

module k_permutation_enumerator_core_checker
	import kperm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic                   next_request,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire logic                   found,
	input  wire logic [POS_W-1:0]       position,
	input  wire logic [VAL_W-1:0]       element_value,
	input  wire logic                   empty_sequence,
	input  wire logic                   last_of_run,
	output int                          mismatch_count,
	output int                          pending_words,
	output int                          words_checked,
	output int                          end_reports
);

	localparam int MAX_VALUES = DEF_MAX_VALUES;
	localparam int MAX_LENGTH = DEF_MAX_LENGTH;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] element_value;
		logic             empty_sequence;
		logic             last_of_run;
	} perm_word_t;

	// predicted enumerator state
	logic [CFG_DATA_W-1:0] count_reg;
	logic [CFG_DATA_W-1:0] length_reg;
	bit                    enum_running;
	logic [VAL_W-1:0]      seq_q [MAX_LENGTH];
	logic [MAX_VALUES-1:0] used_mask;

	perm_word_t expected_words [$];

	task automatic restart_enum();
		enum_running = 1'b0;
		for (int k = 0; k < MAX_LENGTH; k++) seq_q[k] = '0;
		used_mask = '0;
	endtask

	task automatic push_word(input bit f, input int p, input int v, input bit e, input bit l);
		perm_word_t w;
		w.found          = f;
		w.position       = p[POS_W-1:0];
		w.element_value  = v[VAL_W-1:0];
		w.empty_sequence = e;
		w.last_of_run    = l;
		expected_words = {expected_words, w};
	endtask

	task automatic push_end();
		restart_enum();
		push_word(1'b0, 0, 0, 1'b0, 1'b1);
	endtask

	task automatic push_sequence(input int r);
		if (r == 0) begin
			push_word(1'b1, 0, 0, 1'b1, 1'b1);
		end else begin
			for (int k = 0; k < r; k++)
				push_word(1'b1, k, int'(seq_q[k]), 1'b0, k + 1 == r);
		end
	endtask

	// lowest unused value at or above from, lim if none
	function automatic int first_free(input int from, input int lim);
		for (int v = from; v < lim; v++)
			if (!used_mask[v]) return v;
		return lim;
	endfunction

	// lexicographic successor of the current sequence
	task automatic step_successor(input int n, input int r, output bit ok);
		int p;
		int v;
		ok = 1'b0;
		for (int i = r; i > 0; i--) begin
			p = i - 1;
			used_mask[seq_q[p]] = 1'b0;
			v = first_free(int'(seq_q[p]) + 1, n);
			if (v < n) begin
				seq_q[p] = v[VAL_W-1:0];
				used_mask[v] = 1'b1;
				for (int j = p + 1; j < r; j++) begin
					v = first_free(0, n);
					if (v >= n) return;
					seq_q[j] = v[VAL_W-1:0];
					used_mask[v] = 1'b1;
				end
				ok = 1'b1;
				return;
			end
		end
	endtask

	task automatic predict_request();
		int  n;
		int  r;
		bit  ok;
		n = (int'(count_reg) > MAX_VALUES) ? MAX_VALUES : int'(count_reg);
		// too long for the value count or the storage: always the end report
		if (int'(length_reg) > MAX_LENGTH || int'(length_reg) > n) begin
			push_end();
			return;
		end
		r = int'(length_reg);
		if (!enum_running) begin
			restart_enum();
			enum_running = 1'b1;
			for (int k = 0; k < r; k++) begin
				seq_q[k] = k[VAL_W-1:0];
				used_mask[k] = 1'b1;
			end
			push_sequence(r);
			return;
		end
		step_successor(n, r, ok);
		if (!ok) push_end();
		else push_sequence(r);
	endtask

	task automatic compare_word();
		perm_word_t w;
		if (expected_words.size() == 0) begin
			$display("%0t unexpected result word: found %0d position %0d value %0d empty %0d last %0d",
				$time, found, position, element_value, empty_sequence, last_of_run);
			mismatch_count++;
			return;
		end
		w = expected_words.pop_front();
		words_checked++;
		if (!w.found) end_reports++;
		if (found !== w.found) begin
			$display("%0t found mismatch: expected %0d actual %0d", $time, w.found, found);
			mismatch_count++;
		end
		if (position !== w.position) begin
			$display("%0t position mismatch: expected %0d actual %0d",
				$time, w.position, position);
			mismatch_count++;
		end
		if (element_value !== w.element_value) begin
			$display("%0t element_value mismatch: expected %0d actual %0d",
				$time, w.element_value, element_value);
			mismatch_count++;
		end
		if (empty_sequence !== w.empty_sequence) begin
			$display("%0t empty_sequence mismatch: expected %0d actual %0d",
				$time, w.empty_sequence, empty_sequence);
			mismatch_count++;
		end
		if (last_of_run !== w.last_of_run) begin
			$display("%0t last_of_run mismatch: expected %0d actual %0d",
				$time, w.last_of_run, last_of_run);
			mismatch_count++;
		end
	endtask

	// watch the three ports at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = '0;
			length_reg = '0;
			restart_enum();
			expected_words.delete();
			mismatch_count = 0;
			words_checked = 0;
			end_reports = 0;
		end else begin
			if (out_valid && out_ready) compare_word();
			if (cfg_write) begin
				if (cfg_index == REG_VALUE_COUNT) begin
					count_reg = cfg_data;
					restart_enum();
				end else if (cfg_index == REG_SEQUENCE_LENGTH) begin
					length_reg = cfg_data;
					restart_enum();
				end
			end
			if (in_valid && in_ready && next_request) predict_request();
		end
		pending_words = expected_words.size();
	end

endmodule

`default_nettype wire

[tb/sv/k_permutation_enumerator_core_test.sv]
// testbench top for the k-permutation enumerator: clock, reset, stimulus and verdict
`default_nettype none

module k_permutation_enumerator_core_test;
	import kperm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_REQS   = 160;

	// indexes past the register list, writes there are ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   next_request;
	logic                   out_valid;
	logic                   out_ready;
	logic                   found;
	logic [POS_W-1:0]       position;
	logic [VAL_W-1:0]       element_value;
	logic                   empty_sequence;
	logic                   last_of_run;

	int mismatch_count;
	int pending_words;
	int words_checked;
	int end_reports;
	int cycle_count;
	int requests_sent;
	int settings_used;
	bit hold_request;
	bit hold_done;

	k_permutation_enumerator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.next_request  (next_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.position      (position),
		.element_value (element_value),
		.empty_sequence(empty_sequence),
		.last_of_run   (last_of_run)
	);

	k_permutation_enumerator_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.next_request  (next_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.position      (position),
		.element_value (element_value),
		.empty_sequence(empty_sequence),
		.last_of_run   (last_of_run),
		.mismatch_count(mismatch_count),
		.pending_words (pending_words),
		.words_checked (words_checked),
		.end_reports   (end_reports)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t run limit reached with %0d words still expected", $time, pending_words);
		$display("TEST FAILED");
		$finish;
	end

	// receiver: one long hold on request, otherwise stretches of random stall patterns
	initial begin : receiver
		int mode;
		int mode_left;
		int held;
		out_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		held = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_ready <= 1'b0;
				held++;
				if (held >= LONG_HOLD) hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					default: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	task automatic send_word(input bit req);
		@(negedge clk);
		in_valid <= 1'b1;
		next_request <= req;
		do @(posedge clk); while (!in_ready);
		if (req) requests_sent++;
	endtask

	task automatic go_idle(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			next_request <= 1'($urandom_range(0, 1));
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait for every expected word, then let absorbed words clear the block
	task automatic wait_drained();
		go_idle(1);
		while (pending_words != 0) @(negedge clk);
		go_idle(SETTLE_CYCLES);
	endtask

	task automatic set_sizes(input logic [CFG_DATA_W-1:0] n, input logic [CFG_DATA_W-1:0] r);
		wait_drained();
		write_reg(REG_VALUE_COUNT, n);
		write_reg(REG_SEQUENCE_LENGTH, r);
		settings_used++;
	endtask

	// stimulus
	initial begin : stimulus
		int n;
		int r;
		int items;
		int burst;
		int pick;
		bit req;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		next_request = 1'b0;
		hold_request = 1'b0;
		requests_sent = 0;
		settings_used = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset sizes: empty sequence, absorbed word, end, then empty again
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b1);
		// write past the register list must not restart the run
		wait_drained();
		write_reg(REG_SPARE_B, 5'd31);
		send_word(1'b1);

		// full walk of three values taken two at a time, then a restart
		set_sizes(5'd3, 5'd2);
		repeat (8) send_word(1'b1);
		// widest sequences
		set_sizes(5'd16, 5'd16);
		repeat (3) send_word(1'b1);
		// oversized count clamps to the maximum
		set_sizes(5'd31, 5'd16);
		repeat (2) send_word(1'b1);
		// length beyond the maximum
		set_sizes(5'd16, 5'd17);
		send_word(1'b1);
		set_sizes(5'd31, 5'd31);
		send_word(1'b1);
		// one value, and the empty sequence at full count
		set_sizes(5'd1, 5'd1);
		repeat (2) send_word(1'b1);
		set_sizes(5'd16, 5'd0);
		repeat (2) send_word(1'b1);

		// random phases, the first one under a long receiver hold
		requests_sent = 0;
		while (requests_sent < RANDOM_REQS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				n = $urandom_range(1, 5);
				r = $urandom_range(0, (n < 3) ? n : 3);
			end else if (pick == 6) begin
				n = $urandom_range(0, 16);
				r = $urandom_range(n + 1, 31);
			end else if (pick == 7) begin
				n = $urandom_range(17, 31);
				r = $urandom_range(0, 16);
			end else if (pick == 8) begin
				n = 16;
				r = $urandom_range(12, 16);
			end else begin
				n = $urandom_range(0, 31);
				r = $urandom_range(0, 31);
			end
			set_sizes(n[CFG_DATA_W-1:0], r[CFG_DATA_W-1:0]);
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom_range(0, 31)));
			if (!hold_request) hold_request = 1'b1;
			items = $urandom_range(5, 40);
			while (items > 0) begin
				burst = $urandom_range(1, 12);
				while (burst > 0 && items > 0) begin
					req = ($urandom_range(0, 7) != 0);
					send_word(req);
					if (req) items--;
					burst--;
				end
				go_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
			end
		end

		wait_drained();
		$display("covered %0d random requests after the directed part, over %0d size settings",
			requests_sent, settings_used);
		$display("checked %0d result words, %0d of them end reports", words_checked, end_reports);
		if (mismatch_count == 0 && pending_words == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
